@@ design/scan_reflector_pair_midpoint_unit_assert.svh @@
// Assertion macros shared by the reflector pair midpoint unit.
`ifndef SCAN_REFLECTOR_PAIR_MIDPOINT_UNIT_ASSERT_SVH
`define SCAN_REFLECTOR_PAIR_MIDPOINT_UNIT_ASSERT_SVH

`ifndef SYNTH
`define SRPM_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define SRPM_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);
`else
`define SRPM_ASSERT_IMPLIES(label, ante, cons, msg)
`define SRPM_ASSERT_NEVER(label, cond, msg)
`endif

`endif

@@ design/srpm_pkg.sv @@
// Shared constants, types and tables of the reflector pair midpoint unit.
package srpm_pkg;

  localparam int MAX_SAMPLES  = 2048;
  localparam int CORDIC_STEPS = 16;

  localparam int IDX_W     = $clog2(MAX_SAMPLES);
  localparam int CNT_W     = IDX_W + 1;
  localparam int OUT_IDX_W = 11;
  localparam int POS_W     = (IDX_W > OUT_IDX_W) ? IDX_W : OUT_IDX_W;
  localparam int DIFF_W    = POS_W + 1;
  localparam int ANG_W     = DIFF_W + 17;
  localparam int MAG_W     = ANG_W - 1;
  localparam int QUO_BITS  = ANG_W - 23;
  localparam int QK_W      = $clog2(QUO_BITS);
  localparam int FOLD_W    = 24;

  localparam int THR_W      = 16;
  localparam int GAP_W      = 11;
  localparam int CTR_W      = 11;
  localparam int STEP_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_SEL_W  = 2;
  localparam int RNG_W      = 16;
  localparam int MID_W      = 17;

  localparam int XY_W       = 36;
  localparam int SUM_W      = XY_W + 1;
  localparam int Z_W        = 33;
  localparam int ATAN_W     = 30;
  localparam int ATAN_SEL_W = 5;
  localparam int ITER_W     = $clog2(CORDIC_STEPS);
  localparam int GAIN_W     = 30;
  localparam int GAIN_SHIFT = 14;
  localparam int Z_SHIFT    = 10;
  localparam int MID_SHIFT  = 17;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int ANG_2PI     = 6588397;
  localparam int ANG_PI      = 3294199;
  localparam int ANG_HALF_PI = 1647099;
  localparam int GAIN_Q30    = 652032874;
  localparam int MID_LIMIT   = 65535;

  localparam logic signed [FOLD_W-1:0] TWO_PI_S  = FOLD_W'(ANG_2PI);
  localparam logic signed [FOLD_W-1:0] PI_S      = FOLD_W'(ANG_PI);
  localparam logic signed [FOLD_W-1:0] HALF_PI_S = FOLD_W'(ANG_HALF_PI);
  localparam logic signed [SUM_W-1:0]  ROUND_BIAS = SUM_W'(65536);
  localparam logic signed [SUM_W-1:0]  SUM_LIMIT  = SUM_W'(MID_LIMIT);
  localparam logic signed [MID_W-1:0]  MID_MAX_S  = MID_W'(MID_LIMIT);
  localparam logic signed [MID_W-1:0]  MID_MIN_S  = -MID_MAX_S;

  localparam logic [THR_W-1:0]  THRESHOLD_RESET = THR_W'(7000);
  localparam logic [GAP_W-1:0]  LEG_GAP_RESET   = GAP_W'(20);
  localparam logic [CTR_W-1:0]  CENTER_RESET    = CTR_W'(540);
  localparam logic [STEP_W-1:0] STEP_RESET      = STEP_W'(4575);

  typedef enum logic [CFG_SEL_W-1:0] {
    REG_THRESHOLD,
    REG_LEG_GAP,
    REG_CENTER,
    REG_STEP
  } cfg_reg_t;

  typedef enum logic [1:0] {
    LEGS_NONE,
    LEGS_ONE,
    LEGS_BOTH
  } legs_t;

  typedef struct packed {
    logic [THR_W-1:0]  threshold;
    logic [GAP_W-1:0]  leg_gap;
    logic [CTR_W-1:0]  center;
    logic [STEP_W-1:0] step;
  } cfg_t;

  typedef struct packed {
    legs_t             found;
    logic [IDX_W-1:0]  one_idx;
    logic [RNG_W-1:0]  one_rng;
    logic [IDX_W-1:0]  two_idx;
    logic [RNG_W-1:0]  two_rng;
  } leg_job_t;

  function automatic logic [ATAN_W-1:0] atan_q30(input logic [ATAN_SEL_W-1:0] i);
    case (i)
      5'd0:    atan_q30 = 30'h3243F6A8;
      5'd1:    atan_q30 = 30'h1DAC6705;
      5'd2:    atan_q30 = 30'h0FADBAFC;
      5'd3:    atan_q30 = 30'h07F56EA6;
      5'd4:    atan_q30 = 30'h03FEAB76;
      5'd5:    atan_q30 = 30'h01FFD55B;
      5'd6:    atan_q30 = 30'h00FFFAAA;
      5'd7:    atan_q30 = 30'h007FFF55;
      5'd8:    atan_q30 = 30'h003FFFEA;
      5'd9:    atan_q30 = 30'h001FFFFD;
      5'd10:   atan_q30 = 30'h000FFFFF;
      5'd11:   atan_q30 = 30'h0007FFFF;
      5'd12:   atan_q30 = 30'h0003FFFF;
      5'd13:   atan_q30 = 30'h0001FFFF;
      5'd14:   atan_q30 = 30'h0000FFFF;
      5'd15:   atan_q30 = 30'h00007FFF;
      5'd16:   atan_q30 = 30'h00003FFF;
      5'd17:   atan_q30 = 30'h00001FFF;
      5'd18:   atan_q30 = 30'h00000FFF;
      5'd19:   atan_q30 = 30'h000007FF;
      5'd20:   atan_q30 = 30'h000003FF;
      5'd21:   atan_q30 = 30'h000001FF;
      5'd22:   atan_q30 = 30'h000000FF;
      5'd23:   atan_q30 = 30'h0000007F;
      default: atan_q30 = '0;
    endcase
  endfunction

endpackage

@@ design/srpm_front.sv @@
// Sample classifier: counts samples, finds both legs and queues one job per scan.
module srpm_front (
  input  logic               clk,
  input  logic               rst,
  input  srpm_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        intensity,
  input  logic [15:0]        range_mm,
  input  logic               scan_end,
  input  logic               q_full,
  output logic               q_push,
  output srpm_pkg::leg_job_t q_data
);
  import srpm_pkg::*;

  logic [CNT_W-1:0]  count, count_next;
  legs_t             legs, legs_next;
  logic [IDX_W-1:0]  one_idx, one_idx_next, two_idx, two_idx_next;
  logic [RNG_W-1:0]  one_rng, one_rng_next, two_rng, two_rng_next;
  logic [IDX_W-1:0]  idx;
  logic [DIFF_W-1:0] reach;
  logic              hit;
  logic              accept;

  always_comb begin
    accept       = in_valid && !q_full;
    in_stall     = q_full;
    idx          = count[IDX_W-1:0];
    hit          = intensity > cfg.threshold;
    count_next   = count;
    legs_next    = legs;
    one_idx_next = one_idx;
    one_rng_next = one_rng;
    two_idx_next = two_idx;
    two_rng_next = two_rng;
    if (count < CNT_W'(MAX_SAMPLES)) begin
      if (legs == LEGS_NONE && hit) begin
        one_idx_next = idx;
        one_rng_next = range_mm;
        legs_next    = LEGS_ONE;
      end
      count_next = count + CNT_W'(1);
    end
    reach = DIFF_W'(one_idx_next) + DIFF_W'(cfg.leg_gap);
    if (count < CNT_W'(MAX_SAMPLES) && legs_next == LEGS_ONE && hit &&
        DIFF_W'(idx) >= reach) begin
      two_idx_next = idx;
      two_rng_next = range_mm;
      legs_next    = LEGS_BOTH;
    end
    q_push = accept && scan_end;
    q_data = '{found: legs_next, one_idx: one_idx_next, one_rng: one_rng_next,
               two_idx: two_idx_next, two_rng: two_rng_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      legs    <= LEGS_NONE;
      one_idx <= '0;
      one_rng <= '0;
      two_idx <= '0;
      two_rng <= '0;
    end else if (accept) begin
      if (scan_end) begin
        count   <= '0;
        legs    <= LEGS_NONE;
        one_idx <= '0;
        one_rng <= '0;
        two_idx <= '0;
        two_rng <= '0;
      end else begin
        count   <= count_next;
        legs    <= legs_next;
        one_idx <= one_idx_next;
        one_rng <= one_rng_next;
        two_idx <= two_idx_next;
        two_rng <= two_rng_next;
      end
    end
  end

endmodule

@@ design/srpm_queue.sv @@
// Short queue of per-scan leg jobs between the classifier and the solver.
module srpm_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  srpm_pkg::leg_job_t push_data,
  input  logic               pop,
  output srpm_pkg::leg_job_t pop_data,
  output logic               full,
  output logic               empty
);
  import srpm_pkg::*;

  leg_job_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QPTR_W:0]   fill;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      ptr_inc = '0;
    end else begin
      ptr_inc = p + QPTR_W'(1);
    end
  endfunction

  assign full     = fill == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign empty    = fill == '0;
  assign pop_data = entries[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push && !full) begin
        wptr <= ptr_inc(wptr);
      end
      if (pop && !empty) begin
        rptr <= ptr_inc(rptr);
      end
      if ((push && !full) && !(pop && !empty)) begin
        fill <= fill + (QPTR_W + 1)'(1);
      end else if (!(push && !full) && (pop && !empty)) begin
        fill <= fill - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule

@@ design/srpm_back.sv @@
// Leg solver: angle reduction, shared CORDIC rotation, midpoint and result word.
module srpm_back (
  input  logic                                clk,
  input  logic                                rst,
  input  srpm_pkg::cfg_t                      cfg,
  input  logic                                q_empty,
  input  srpm_pkg::leg_job_t                  q_data,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                approachable,
  output logic signed [srpm_pkg::MID_W-1:0]   mid_x_mm,
  output logic signed [srpm_pkg::MID_W-1:0]   mid_y_mm,
  output logic [srpm_pkg::OUT_IDX_W-1:0]      first_leg_index,
  output logic [srpm_pkg::OUT_IDX_W-1:0]      second_leg_index
);
  import srpm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_REDUCE,
    ST_WRAP,
    ST_FOLD,
    ST_ROTATE,
    ST_LEG_DONE,
    ST_SUM,
    ST_ROUND,
    ST_FINISH
  } state_t;

  state_t                    state;
  leg_job_t                  job;
  logic                      leg;
  logic [MAG_W-1:0]          mag;
  logic                      neg;
  logic [QK_W-1:0]           k;
  logic signed [FOLD_W-1:0]  ang;
  logic signed [XY_W-1:0]    x, y, x1, y1;
  logic signed [Z_W-1:0]     z;
  logic [ITER_W-1:0]         iter;
  logic                      flip;
  logic signed [SUM_W-1:0]   sx, sy;
  logic signed [MID_W-1:0]   held_x, held_y;

  logic [IDX_W-1:0]          cur_idx;
  logic [RNG_W-1:0]          cur_rng;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [ANG_W-1:0]   prod, prod_neg;
  logic [MAG_W-1:0]          red_sub;
  logic signed [FOLD_W-1:0]  rem_s, a_sign, a_wrap, a_fold;
  logic                      fold_flip;
  logic [RNG_W+GAIN_W-1:0]   gprod;
  logic signed [XY_W-1:0]    dx, dy, xf, yf;
  logic signed [Z_W-1:0]     at_s;

  function automatic logic signed [MID_W-1:0] round_sat(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] t;
    t = (s + ROUND_BIAS) >>> MID_SHIFT;
    if (t > SUM_LIMIT) begin
      round_sat = MID_MAX_S;
    end else if (t < -SUM_LIMIT) begin
      round_sat = MID_MIN_S;
    end else begin
      round_sat = MID_W'(t);
    end
  endfunction

  always_comb begin
    q_pop    = (state == ST_IDLE) && !q_empty;
    cur_idx  = leg ? job.two_idx : job.one_idx;
    cur_rng  = leg ? job.two_rng : job.one_rng;
    diff     = $signed(DIFF_W'(cur_idx) - DIFF_W'(cfg.center));
    prod     = diff * $signed({1'b0, cfg.step});
    prod_neg = -prod;
    red_sub  = MAG_W'(ANG_2PI) << k;

    rem_s  = $signed({1'b0, mag[FOLD_W-2:0]});
    a_sign = neg ? -rem_s : rem_s;
    if (a_sign > PI_S) begin
      a_wrap = a_sign - TWO_PI_S;
    end else if (a_sign < -PI_S) begin
      a_wrap = a_sign + TWO_PI_S;
    end else begin
      a_wrap = a_sign;
    end

    fold_flip = 1'b1;
    if (ang > HALF_PI_S) begin
      a_fold = ang - PI_S;
    end else if (ang < -HALF_PI_S) begin
      a_fold = ang + PI_S;
    end else begin
      a_fold    = ang;
      fold_flip = 1'b0;
    end
    gprod = cur_rng * GAIN_W'(GAIN_Q30);

    dx   = y >>> iter;
    dy   = x >>> iter;
    at_s = $signed(Z_W'(atan_q30(ATAN_SEL_W'(iter))));
    xf   = flip ? -x : x;
    yf   = flip ? -y : y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      held_x    <= '0;
      held_y    <= '0;
      leg       <= 1'b0;
    end else begin
      if (state == ST_FINISH && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            job <= q_data;
            leg <= 1'b0;
            if (q_data.found == LEGS_BOTH) begin
              state <= ST_ANGLE;
            end else begin
              state <= ST_FINISH;
            end
          end
        end
        ST_ANGLE: begin
          mag   <= prod[ANG_W-1] ? prod_neg[MAG_W-1:0] : prod[MAG_W-1:0];
          neg   <= prod[ANG_W-1];
          k     <= QK_W'(QUO_BITS - 1);
          state <= ST_REDUCE;
        end
        ST_REDUCE: begin
          if (mag >= red_sub) begin
            mag <= mag - red_sub;
          end
          if (k == '0) begin
            state <= ST_WRAP;
          end else begin
            k <= k - QK_W'(1);
          end
        end
        ST_WRAP: begin
          ang   <= a_wrap;
          state <= ST_FOLD;
        end
        ST_FOLD: begin
          z     <= Z_W'(a_fold) <<< Z_SHIFT;
          flip  <= fold_flip;
          x     <= $signed(XY_W'(gprod >> GAIN_SHIFT));
          y     <= '0;
          iter  <= '0;
          state <= ST_ROTATE;
        end
        ST_ROTATE: begin
          if (!z[Z_W-1]) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - at_s;
          end else begin
            x <= x + dx;
            y <= y - dy;
            z <= z + at_s;
          end
          if (iter == ITER_W'(CORDIC_STEPS - 1)) begin
            state <= ST_LEG_DONE;
          end else begin
            iter <= iter + ITER_W'(1);
          end
        end
        ST_LEG_DONE: begin
          if (!leg) begin
            x1    <= xf;
            y1    <= yf;
            leg   <= 1'b1;
            state <= ST_ANGLE;
          end else begin
            x     <= xf;
            y     <= yf;
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          sx    <= SUM_W'(x1) + SUM_W'(x);
          sy    <= SUM_W'(y1) + SUM_W'(y);
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          held_x <= round_sat(sx);
          held_y <= round_sat(sy);
          state  <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!out_valid || !out_stall) begin
            approachable     <= job.found == LEGS_BOTH;
            mid_x_mm         <= held_x;
            mid_y_mm         <= held_y;
            first_leg_index  <= (job.found != LEGS_NONE) ? OUT_IDX_W'(job.one_idx) : '0;
            second_leg_index <= (job.found == LEGS_BOTH) ? OUT_IDX_W'(job.two_idx) : '0;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/scan_reflector_pair_midpoint_unit.sv @@
// Top level of the reflector pair midpoint unit: configuration registers and wiring.
// The unit takes one scan sample per cycle and stalls its input only when two finished
// scans are already waiting for the solver. Each scan end queues one job; a scan without
// both legs goes from the queue straight to its result word, while a scan with both legs
// passes the shift-and-subtract angle reduction and then the single CORDIC rotator that
// serves both legs one after the other.
`include "scan_reflector_pair_midpoint_unit_assert.svh"

module scan_reflector_pair_midpoint_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [srpm_pkg::CFG_SEL_W-1:0]      cfg_index,
  input  logic [srpm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [15:0]                         intensity,
  input  logic [15:0]                         range_mm,
  input  logic                                scan_end,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                approachable,
  output logic signed [srpm_pkg::MID_W-1:0]   mid_x_mm,
  output logic signed [srpm_pkg::MID_W-1:0]   mid_y_mm,
  output logic [srpm_pkg::OUT_IDX_W-1:0]      first_leg_index,
  output logic [srpm_pkg::OUT_IDX_W-1:0]      second_leg_index
);
  import srpm_pkg::*;

  cfg_t     cfg;
  logic     q_push, q_pop, q_full, q_empty;
  leg_job_t q_push_data, q_pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= THRESHOLD_RESET;
      cfg.leg_gap   <= LEG_GAP_RESET;
      cfg.center    <= CENTER_RESET;
      cfg.step      <= STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD: cfg.threshold <= cfg_data[THR_W-1:0];
        REG_LEG_GAP:   cfg.leg_gap   <= cfg_data[GAP_W-1:0];
        REG_CENTER:    cfg.center    <= cfg_data[CTR_W-1:0];
        REG_STEP:      cfg.step      <= cfg_data[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  srpm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .intensity(intensity),
    .range_mm (range_mm),
    .scan_end (scan_end),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_push_data)
  );

  srpm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_push_data),
    .pop      (q_pop),
    .pop_data (q_pop_data),
    .full     (q_full),
    .empty    (q_empty)
  );

  srpm_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_empty         (q_empty),
    .q_data          (q_pop_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .approachable    (approachable),
    .mid_x_mm        (mid_x_mm),
    .mid_y_mm        (mid_y_mm),
    .first_leg_index (first_leg_index),
    .second_leg_index(second_leg_index)
  );

  `SRPM_ASSERT_IMPLIES(a_no_second_leg, out_valid && !approachable, second_leg_index == '0, "second leg index reported without both legs")
  `SRPM_ASSERT_IMPLIES(a_mid_range, out_valid, mid_x_mm >= MID_MIN_S && mid_y_mm >= MID_MIN_S, "midpoint below saturation limit")
  `SRPM_ASSERT_NEVER(a_pop_empty, q_pop && q_empty, "solver took a job from an empty queue")

endmodule

@@ tb/scan_reflector_pair_midpoint_unit_test.sv @@
// Self-checking testbench for the scan reflector pair midpoint unit.
`timescale 1ns / 1ps

module scan_reflector_pair_midpoint_unit_test;
  import srpm_pkg::*;

  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 500;
  localparam int REPORT_LIMIT  = 10;
  localparam int CYCLE_LIMIT   = 600000;

  typedef struct packed {
    logic                 approachable;
    logic [MID_W-1:0]     mid_x;
    logic [MID_W-1:0]     mid_y;
    logic [OUT_IDX_W-1:0] first_idx;
    logic [OUT_IDX_W-1:0] second_idx;
  } midpoint_word_t;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [CFG_SEL_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic [15:0]             intensity;
  logic [15:0]             range_mm;
  logic                    scan_end;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    approachable;
  logic signed [MID_W-1:0] mid_x_mm;
  logic signed [MID_W-1:0] mid_y_mm;
  logic [OUT_IDX_W-1:0]    first_leg_index;
  logic [OUT_IDX_W-1:0]    second_leg_index;

  cfg_t                active_cfg;
  int unsigned         scan_pos;
  legs_t               leg_state;
  int unsigned         leg1_idx;
  int unsigned         leg2_idx;
  logic [RNG_W-1:0]    leg1_rng;
  logic [RNG_W-1:0]    leg2_rng;
  logic [MID_W-1:0]    held_x;
  logic [MID_W-1:0]    held_y;
  midpoint_word_t      pending_midpoints[$];

  longint arctan_table [24] = '{
    'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
    'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
    'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
    'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F
  };

  int          mismatch_count = 0;
  int unsigned cycle_count = 0;
  int          gap_limit;
  int          burst_left;
  int          hold_requests = 0;
  int          holds_served = 0;
  int          hold_left = 0;
  int unsigned stall_tick = 0;
  int          stall_mode = 0;

  scan_reflector_pair_midpoint_unit dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .intensity        (intensity),
    .range_mm         (range_mm),
    .scan_end         (scan_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .approachable     (approachable),
    .mid_x_mm         (mid_x_mm),
    .mid_y_mm         (mid_y_mm),
    .first_leg_index  (first_leg_index),
    .second_leg_index (second_leg_index)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // The receiver periodically picks a new stall pattern; a requested hold-off wins.
  always @(negedge clk) begin
    stall_tick++;
    if (stall_tick % 150 == 0) begin
      stall_mode = $urandom_range(3, 0);
    end
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      case (stall_mode)
        0: out_stall = 1'b0;
        1: out_stall = ($urandom_range(3, 0) == 0);
        2: out_stall = ($urandom_range(3, 0) != 0);
        default: out_stall = stall_tick[3];
      endcase
    end
  end

  function automatic void leg_to_xy(input int unsigned idx, input logic [RNG_W-1:0] rng,
                                    output longint px, output longint py);
    longint ang, x, y, z, dx, dy;
    bit flip;
    ang = (longint'(idx) - longint'(active_cfg.center)) * longint'(active_cfg.step);
    ang = ang % ANG_2PI;
    if (ang > ANG_PI) ang -= ANG_2PI;
    if (ang < -ANG_PI) ang += ANG_2PI;
    flip = 1'b0;
    if (ang > ANG_HALF_PI) begin
      ang -= ANG_PI;
      flip = 1'b1;
    end else if (ang < -ANG_HALF_PI) begin
      ang += ANG_PI;
      flip = 1'b1;
    end
    x = (longint'(rng) * longint'(GAIN_Q30)) >>> GAIN_SHIFT;
    y = 0;
    z = ang * 1024;
    for (int k = 0; k < CORDIC_STEPS && k < 24; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= arctan_table[k];
      end else begin
        x += dx;
        y -= dy;
        z += arctan_table[k];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    px = x;
    py = y;
  endfunction

  function automatic logic [MID_W-1:0] halve_and_clamp(input longint total);
    longint m;
    m = (total + 65536) >>> MID_SHIFT;
    if (m > MID_LIMIT) m = MID_LIMIT;
    if (m < -MID_LIMIT) m = -MID_LIMIT;
    return m[MID_W-1:0];
  endfunction

  function automatic void predict_sample(input logic [15:0] inten, input logic [15:0] rng,
                                         input bit last);
    bit hit;
    longint x1, y1, x2, y2;
    midpoint_word_t word;
    if (scan_pos < MAX_SAMPLES) begin
      hit = inten > active_cfg.threshold;
      if (leg_state == LEGS_NONE && hit) begin
        leg1_idx = scan_pos;
        leg1_rng = rng;
        leg_state = LEGS_ONE;
      end
      if (leg_state == LEGS_ONE && hit && scan_pos >= leg1_idx + active_cfg.leg_gap) begin
        leg2_idx = scan_pos;
        leg2_rng = rng;
        leg_state = LEGS_BOTH;
      end
      scan_pos++;
    end
    if (last) begin
      if (leg_state == LEGS_BOTH) begin
        leg_to_xy(leg1_idx, leg1_rng, x1, y1);
        leg_to_xy(leg2_idx, leg2_rng, x2, y2);
        held_x = halve_and_clamp(x1 + x2);
        held_y = halve_and_clamp(y1 + y2);
      end
      word.approachable = (leg_state == LEGS_BOTH);
      word.mid_x = held_x;
      word.mid_y = held_y;
      word.first_idx = (leg_state != LEGS_NONE) ? leg1_idx[OUT_IDX_W-1:0] : '0;
      word.second_idx = (leg_state == LEGS_BOTH) ? leg2_idx[OUT_IDX_W-1:0] : '0;
      pending_midpoints.push_back(word);
      scan_pos = 0;
      leg_state = LEGS_NONE;
      leg1_idx = 0;
      leg2_idx = 0;
      leg1_rng = '0;
      leg2_rng = '0;
    end
  endfunction

  always @(posedge clk) begin : check_words
    midpoint_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_midpoints.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("Unexpected word: appr=%0d x=%0d y=%0d first=%0d second=%0d",
                   approachable, mid_x_mm, mid_y_mm, first_leg_index, second_leg_index);
        end
      end else begin
        want = pending_midpoints.pop_front();
        if (approachable !== want.approachable || mid_x_mm !== want.mid_x ||
            mid_y_mm !== want.mid_y || first_leg_index !== want.first_idx ||
            second_leg_index !== want.second_idx) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("Mismatch: expected appr=%0d x=%0d y=%0d first=%0d second=%0d",
                     want.approachable, $signed(want.mid_x), $signed(want.mid_y),
                     want.first_idx, want.second_idx);
            $display("          actual   appr=%0d x=%0d y=%0d first=%0d second=%0d",
                     approachable, mid_x_mm, mid_y_mm, first_leg_index, second_leg_index);
          end
        end
      end
    end
  end

  task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = sel;
    cfg_data = value;
    @(posedge clk);
    case (sel)
      REG_THRESHOLD: active_cfg.threshold = value[THR_W-1:0];
      REG_LEG_GAP:   active_cfg.leg_gap = value[GAP_W-1:0];
      REG_CENTER:    active_cfg.center = value[CTR_W-1:0];
      REG_STEP:      active_cfg.step = value[STEP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_sample(input logic [15:0] inten, input logic [15:0] rng, input bit last);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(gap_limit, 0)) @(negedge clk);
      burst_left = $urandom_range(32, 1);
    end
    intensity = inten;
    range_mm = rng;
    scan_end = last;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predict_sample(inten, rng, last);
    burst_left--;
    @(negedge clk);
  endtask

  // Hits are drawn above the threshold with the given percentage; a noisy scan
  // takes intensities from the whole field instead.
  task automatic send_scan(input int len, input int pct, input bit noisy);
    logic [15:0] inten;
    logic [15:0] rng;
    for (int i = 0; i < len; i++) begin
      if (noisy) begin
        inten = 16'($urandom_range(65535, 0));
      end else if ($urandom_range(99, 0) < pct && active_cfg.threshold != 16'hFFFF) begin
        inten = 16'($urandom_range(65535, active_cfg.threshold + 1));
      end else begin
        inten = 16'($urandom_range(active_cfg.threshold, 0));
      end
      case ($urandom_range(9, 0))
        0: rng = 16'h0000;
        1: rng = 16'hFFFF;
        default: rng = 16'($urandom_range(65535, 0));
      endcase
      send_sample(inten, rng, i == len - 1);
    end
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_midpoints.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_reset_settings();
    gap_limit = 3;
    send_scan(40, 10, 1'b0);
    send_scan(64, 10, 1'b0);
    wait_idle();
  endtask

  task automatic test_directed_corners();
    write_reg(REG_THRESHOLD, 16'd7000);
    write_reg(REG_LEG_GAP, 16'd3);
    write_reg(REG_CENTER, 16'd2);
    write_reg(REG_STEP, 16'd40000);
    send_sample(16'd7000, 16'd100, 1'b0);
    send_sample(16'd7001, 16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 16'h0000, 1'b0);
    send_sample(16'h0000, 16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 16'hFFFF, 1'b1);
    send_sample(16'h0000, 16'h0000, 1'b1);
    send_sample(16'hFFFF, 16'd1234, 1'b0);
    send_sample(16'h0000, 16'd4321, 1'b0);
    send_sample(16'hFFFF, 16'd999, 1'b1);
    wait_idle();
    // With no gap and no angle step one sample serves as both legs at zero bearing.
    write_reg(REG_LEG_GAP, 16'd0);
    write_reg(REG_STEP, 16'd0);
    send_sample(16'hFFFF, 16'hFFFF, 1'b1);
    send_sample(16'd40000, 16'd1, 1'b1);
    wait_idle();
    write_reg(REG_THRESHOLD, 16'd0);
    write_reg(REG_LEG_GAP, 16'd1);
    write_reg(REG_CENTER, 16'd0);
    write_reg(REG_STEP, 16'hFFFF);
    send_sample(16'd1, 16'hFFFF, 1'b0);
    send_sample(16'd1, 16'hFFFF, 1'b1);
    wait_idle();
    write_reg(REG_CENTER, 16'hFFFF);
    send_sample(16'd1, 16'hFFFF, 1'b0);
    send_sample(16'd0, 16'd0, 1'b0);
    send_sample(16'hFFFF, 16'hFFFF, 1'b1);
    wait_idle();
  endtask

  task automatic test_full_queue();
    write_reg(REG_THRESHOLD, 16'd7000);
    write_reg(REG_LEG_GAP, 16'd1);
    write_reg(REG_CENTER, 16'd540);
    write_reg(REG_STEP, 16'd4575);
    gap_limit = 0;
    hold_requests++;
    @(negedge clk);
    repeat (8) send_scan(3, 100, 1'b0);
    wait_idle();
  endtask

  // The first leg falls on the last stored index; later hits lie past the store and
  // must not become the second leg.
  task automatic test_store_overflow();
    int len;
    int hot_from;
    write_reg(REG_THRESHOLD, 16'd7000);
    write_reg(REG_LEG_GAP, 16'd1);
    gap_limit = 1;
    len = MAX_SAMPLES + 8;
    hot_from = MAX_SAMPLES - 1;
    for (int i = 0; i < len; i++) begin
      send_sample((i >= hot_from) ? 16'hFFFF : 16'($urandom_range(7000, 0)),
                  16'($urandom_range(65535, 0)), i == len - 1);
    end
    wait_idle();
  endtask

  task automatic test_random_scans();
    int sent;
    int len;
    logic [15:0] v16;
    logic [10:0] v11;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(1, 0)) begin
        case ($urandom_range(9, 0))
          0: v16 = 16'h0000;
          1: v16 = 16'hFFFF;
          2: v16 = THRESHOLD_RESET;
          default: v16 = 16'($urandom_range(65535, 0));
        endcase
        write_reg(REG_THRESHOLD, v16);
      end
      if ($urandom_range(1, 0)) begin
        case ($urandom_range(9, 0))
          0: v11 = 11'd0;
          1: v11 = 11'h7FF;
          2: v11 = LEG_GAP_RESET;
          default: v11 = 11'($urandom_range(30, 1));
        endcase
        write_reg(REG_LEG_GAP, {5'($urandom), v11});
      end
      if ($urandom_range(1, 0)) begin
        case ($urandom_range(5, 0))
          0: v11 = 11'd0;
          1: v11 = 11'h7FF;
          default: v11 = 11'($urandom_range(2047, 0));
        endcase
        write_reg(REG_CENTER, {5'($urandom), v11});
      end
      if ($urandom_range(1, 0)) begin
        case ($urandom_range(7, 0))
          0: v16 = 16'h0000;
          1: v16 = 16'h0001;
          2: v16 = 16'hFFFF;
          default: v16 = 16'($urandom_range(65535, 0));
        endcase
        write_reg(REG_STEP, v16);
      end
      case ($urandom_range(2, 0))
        0: gap_limit = 0;
        1: gap_limit = 2;
        default: gap_limit = 6;
      endcase
      if ($urandom_range(7, 0) == 0) begin
        hold_requests++;
      end
      repeat ($urandom_range(6, 1)) begin
        len = ($urandom_range(9, 0) == 0) ? $urandom_range(120, 41) : $urandom_range(40, 1);
        send_scan(len, $urandom_range(40, 5), $urandom_range(9, 0) == 0);
        sent += len;
      end
      wait_idle();
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_THRESHOLD;
    cfg_data = '0;
    in_valid = 1'b0;
    intensity = '0;
    range_mm = '0;
    scan_end = 1'b0;
    gap_limit = 3;
    burst_left = 0;
    active_cfg = '{THRESHOLD_RESET, LEG_GAP_RESET, CENTER_RESET, STEP_RESET};
    scan_pos = 0;
    leg_state = LEGS_NONE;
    leg1_idx = 0;
    leg2_idx = 0;
    leg1_rng = '0;
    leg2_rng = '0;
    held_x = '0;
    held_y = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_settings();
    test_directed_corners();
    test_full_queue();
    test_store_overflow();
    test_random_scans();
    wait_idle();

    if (mismatch_count == 0 && pending_midpoints.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/srpm_pkg.sv
design/srpm_front.sv
design/srpm_queue.sv
design/srpm_back.sv
design/scan_reflector_pair_midpoint_unit.sv
tb/scan_reflector_pair_midpoint_unit_test.sv
